// File: sv/fsksd_pkg.sv
package fsksd_pkg;

    localparam int WINDOW_LEN      = 24;
    localparam int COEF_SCALE_BITS = 12;
    localparam int POS_W           = $clog2(WINDOW_LEN);
    localparam int SAMPLE_W        = 16;
    localparam int DIFF_W          = SAMPLE_W + 1;
    localparam int COEF_W          = COEF_SCALE_BITS + 2;
    localparam int ACC_W           = 34;
    localparam int SQ_PART_W       = ACC_W / 2;
    localparam int MUL_W           = SQ_PART_W + 1;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int ENERGY_W        = 2 * ACC_W;
    localparam int WORD_W          = 32;
    localparam int OFFSET_W        = 5;
    localparam int CNT_W           = 6;
    localparam int OUT_DATA_W      = 40;
    localparam int STEP_W          = 4;

    // Phase advance per sample for the two bins.
    localparam int SPACE_BIN = 3;
    localparam int MARK_BIN  = 4;
    localparam int COS_SHIFT = WINDOW_LEN / 4;

    // Back-end sequencer steps. Each product step names the product formed in that
    // cycle; the product registered in the previous step is consumed alongside.
    localparam logic [STEP_W-1:0] ST_COS    = 4'd0;
    localparam logic [STEP_W-1:0] ST_SIN    = 4'd1;
    localparam logic [STEP_W-1:0] ST_RE_HH  = 4'd2;
    localparam logic [STEP_W-1:0] ST_RE_HL  = 4'd3;
    localparam logic [STEP_W-1:0] ST_RE_LL  = 4'd4;
    localparam logic [STEP_W-1:0] ST_IM_HH  = 4'd5;
    localparam logic [STEP_W-1:0] ST_IM_HL  = 4'd6;
    localparam logic [STEP_W-1:0] ST_IM_LL  = 4'd7;
    localparam logic [STEP_W-1:0] ST_TAIL   = 4'd8;
    localparam logic [STEP_W-1:0] ST_DECIDE = 4'd9;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [POS_W-1:0]         ph_space;
        logic [POS_W-1:0]         ph_mark;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic              active;
        logic [STEP_W-1:0] step;
    } lane_ctl_t;

    // sin(k * 15 deg) for k = 0..6 in Q30, rounded to the coefficient scale.
    function automatic logic signed [COEF_W-1:0] quarter_coef(input logic [2:0] k);
        logic [63:0] q30;
        logic [63:0] v;
        case (k)
            3'd0:    q30 = 64'd0;
            3'd1:    q30 = 64'd277904834;
            3'd2:    q30 = 64'd536870912;
            3'd3:    q30 = 64'd759250125;
            3'd4:    q30 = 64'd929887697;
            3'd5:    q30 = 64'd1037154959;
            default: q30 = 64'd1073741824;
        endcase
        v = (q30 + (64'd1 << (29 - COEF_SCALE_BITS))) >> (30 - COEF_SCALE_BITS);
        return COEF_W'(v);
    endfunction

    // Rounded sine of n * 15 deg for n in 0..23.
    function automatic logic signed [COEF_W-1:0] sin24(input logic [POS_W-1:0] n);
        logic [POS_W-1:0] m;
        logic             neg;
        if (n <= POS_W'(6)) begin
            m   = n;
            neg = 1'b0;
        end else if (n <= POS_W'(12)) begin
            m   = POS_W'(12) - n;
            neg = 1'b0;
        end else if (n <= POS_W'(18)) begin
            m   = n - POS_W'(12);
            neg = 1'b1;
        end else begin
            m   = POS_W'(WINDOW_LEN) - n;
            neg = 1'b1;
        end
        return neg ? -quarter_coef(m[2:0]) : quarter_coef(m[2:0]);
    endfunction

endpackage

// File: sv/fsksd_front.sv
module fsksd_front
    import fsksd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,
    input  logic                s_axis_tlast,
    input  logic                queue_full,
    output logic                push_valid,
    output item_t               push_item
);

    logic signed [SAMPLE_W-1:0] hist_reg [WINDOW_LEN];
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;
    logic [POS_W-1:0]           ph_space_reg;
    logic [POS_W-1:0]           ph_space_next;
    logic [POS_W-1:0]           ph_mark_reg;
    logic [POS_W-1:0]           ph_mark_next;
    logic [POS_W:0]             space_sum;
    logic [POS_W:0]             mark_sum;
    logic                       accept;

    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        pos_next  = (pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_reg + POS_W'(1);
        space_sum = {1'b0, ph_space_reg} + (POS_W + 1)'(SPACE_BIN);
        mark_sum  = {1'b0, ph_mark_reg} + (POS_W + 1)'(MARK_BIN);
        ph_space_next = (space_sum >= (POS_W + 1)'(WINDOW_LEN)) ?
                        POS_W'(space_sum - (POS_W + 1)'(WINDOW_LEN)) : POS_W'(space_sum);
        ph_mark_next  = (mark_sum >= (POS_W + 1)'(WINDOW_LEN)) ?
                        POS_W'(mark_sum - (POS_W + 1)'(WINDOW_LEN)) : POS_W'(mark_sum);
    end

    // The queue entry carries the window difference and the phases of the
    // ring position that the sample advances to.
    always_comb begin
        push_valid         = accept;
        push_item.diff     = DIFF_W'(signed'(s_axis_tdata)) - DIFF_W'(hist_reg[pos_reg]);
        push_item.ph_space = ph_space_next;
        push_item.ph_mark  = ph_mark_next;
        push_item.last     = s_axis_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            ph_space_reg <= '0;
            ph_mark_reg  <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (accept) begin
            hist_reg[pos_reg] <= signed'(s_axis_tdata);
            pos_reg           <= pos_next;
            ph_space_reg      <= ph_space_next;
            ph_mark_reg       <= ph_mark_next;
        end
    end

endmodule

// File: sv/fsksd_queue.sv
module fsksd_queue
    import fsksd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t pop_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push_valid && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: sv/fsksd_lane.sv
module fsksd_lane
    import fsksd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lane_ctl_t                ctl,
    input  logic signed [DIFF_W-1:0] diff,
    input  logic [POS_W-1:0]         phase,
    output logic [ENERGY_W-1:0]      energy
);

    logic signed [ACC_W-1:0]   re_acc_reg;
    logic signed [ACC_W-1:0]   im_acc_reg;
    logic [ENERGY_W-1:0]       energy_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [MUL_W-1:0]   op_a;
    logic signed [MUL_W-1:0]   op_b;
    logic [POS_W:0]            cos_sum;
    logic [POS_W-1:0]          cos_idx;
    logic signed [ACC_W-1:0]   mag_src;
    logic [ACC_W-1:0]          mag;
    logic [SQ_PART_W-1:0]      mag_hi;
    logic [SQ_PART_W-1:0]      mag_lo;
    logic [ENERGY_W-1:0]       sq_term;

    assign energy = energy_reg;

    always_comb begin
        cos_sum = {1'b0, phase} + (POS_W + 1)'(COS_SHIFT);
        cos_idx = (cos_sum >= (POS_W + 1)'(WINDOW_LEN)) ?
                  POS_W'(cos_sum - (POS_W + 1)'(WINDOW_LEN)) : POS_W'(cos_sum);
    end

    // The magnitude of an accumulator is squared as two halves:
    // m^2 = hi^2 * 2^(2P) + 2 * hi * lo * 2^P + lo^2.
    always_comb begin
        mag_src = (ctl.step <= ST_RE_LL) ? re_acc_reg : im_acc_reg;
        mag     = mag_src[ACC_W-1] ? ACC_W'(-mag_src) : ACC_W'(mag_src);
        mag_hi  = mag[ACC_W-1:SQ_PART_W];
        mag_lo  = mag[SQ_PART_W-1:0];
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (ctl.step)
            ST_COS: begin
                op_a = MUL_W'(diff);
                op_b = MUL_W'(sin24(cos_idx));
            end
            ST_SIN: begin
                op_a = MUL_W'(diff);
                op_b = MUL_W'(sin24(phase));
            end
            ST_RE_HH, ST_IM_HH: begin
                op_a = signed'({1'b0, mag_hi});
                op_b = signed'({1'b0, mag_hi});
            end
            ST_RE_HL, ST_IM_HL: begin
                op_a = signed'({1'b0, mag_hi});
                op_b = signed'({1'b0, mag_lo});
            end
            ST_RE_LL, ST_IM_LL: begin
                op_a = signed'({1'b0, mag_lo});
                op_b = signed'({1'b0, mag_lo});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign sq_term = ENERGY_W'(prod_reg[2*SQ_PART_W-1:0]);

    always_ff @(posedge aclk) begin
        if (ctl.active) begin
            prod_reg <= op_a * op_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.active) begin
            unique case (ctl.step)
                ST_RE_HL, ST_IM_HL: energy_reg <= (ctl.step == ST_RE_HL ? '0 : energy_reg)
                                                  + (sq_term << (2 * SQ_PART_W));
                ST_RE_LL, ST_IM_LL: energy_reg <= energy_reg + (sq_term << (SQ_PART_W + 1));
                ST_IM_HH, ST_TAIL:  energy_reg <= energy_reg + sq_term;
                default:            energy_reg <= energy_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            re_acc_reg <= '0;
            im_acc_reg <= '0;
        end else if (ctl.active) begin
            if (ctl.step == ST_SIN) begin
                re_acc_reg <= re_acc_reg + prod_reg[ACC_W-1:0];
            end
            if (ctl.step == ST_RE_HH) begin
                im_acc_reg <= im_acc_reg + prod_reg[ACC_W-1:0];
            end
        end
    end

endmodule

// File: sv/fsksd_back.sv
module fsksd_back
    import fsksd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [OFFSET_W-1:0]   cfg_data,
    input  logic                  queue_empty,
    input  item_t                 pop_item,
    output logic                  pop,
    output lane_ctl_t             ctl,
    output item_t                 cur_item,
    input  logic [ENERGY_W-1:0]   space_energy,
    input  logic [ENERGY_W-1:0]   mark_energy,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser
);

    logic                  active_reg;
    logic [STEP_W-1:0]     step_reg;
    item_t                 item_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic                  run_start_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [WORD_W-1:0]     word_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    logic                  finish;
    logic                  bit_val;
    logic [CNT_W-1:0]      rem_start;
    logic [CNT_W-1:0]      rem_after;
    logic [WORD_W-1:0]     word_start;
    logic [WORD_W-1:0]     word_after;
    logic                  word_full;
    logic                  word_valid;
    logic [WORD_W-1:0]     word_out;
    logic                  run_start_next;
    logic [CNT_W-1:0]      rem_next;
    logic [WORD_W-1:0]     word_next;

    assign cfg_ready     = 1'b1;
    assign pop           = !active_reg && !queue_empty;
    assign ctl.active    = active_reg;
    assign ctl.step      = step_reg;
    assign cur_item      = item_reg;
    assign finish        = active_reg && (step_reg == ST_DECIDE)
                           && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Bit decision and word packing. The offset is applied at the first
    // sample of a run; a flushed partial word is left-aligned.
    always_comb begin
        bit_val    = (mark_energy >= space_energy);
        rem_start  = run_start_reg ? (CNT_W'(WORD_W) - CNT_W'(offset_reg)) : rem_reg;
        word_start = run_start_reg ? '0 : word_reg;
        word_after = {word_start[WORD_W-2:0], bit_val};
        rem_after  = rem_start - CNT_W'(1);
        word_full  = (rem_after == '0);
        word_valid = word_full || item_reg.last;
        word_out   = word_full ? word_after : (word_after << rem_after);
        if (item_reg.last) begin
            run_start_next = 1'b1;
            rem_next       = CNT_W'(WORD_W);
            word_next      = '0;
        end else begin
            run_start_next = 1'b0;
            rem_next       = word_full ? CNT_W'(WORD_W) : rem_after;
            word_next      = word_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= pop_item;
        end
        if (finish) begin
            out_data_reg <= OUT_DATA_W'({(word_valid ? word_out : {WORD_W{1'b0}}), bit_val});
            out_user_reg <= word_valid;
            rem_reg      <= rem_next;
            word_reg     <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            step_reg      <= ST_COS;
            offset_reg    <= '0;
            run_start_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                offset_reg <= cfg_data;
            end
            if (pop) begin
                active_reg <= 1'b1;
                step_reg   <= ST_COS;
            end else if (finish) begin
                active_reg <= 1'b0;
            end else if (active_reg && step_reg != ST_DECIDE) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (finish) begin
                run_start_reg <= run_start_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: sv/fsk_sliding_dft_demodulator.sv
// An accepted sample passes through the queue, the item register and the steps ST_COS to ST_DECIDE.
// The back end works on one sample at a time, set by each tone lane's single shared multiplier,
// which forms two coefficient products and six partial squares per sample.
// A two-entry queue lets the input take samples while a result waits at the output.
// Reset (aresetn low, synchronous) clears the history, accumulators and offset and restarts packing;
// the block is ready in the first cycle after reset, with no clearing pass.
module fsk_sliding_dft_demodulator
    import fsksd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    input  logic                  s_axis_tlast,   // last_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] decided_bit, [32:1] packed_word
    output logic                  m_axis_tuser,   // [0] word_valid
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [OFFSET_W-1:0]   cfg_data        // bit_offset
);

    logic                push_valid;
    item_t               push_item;
    logic                queue_full;
    logic                queue_empty;
    logic                pop;
    item_t               pop_item;
    item_t               cur_item;
    lane_ctl_t           ctl;
    logic [ENERGY_W-1:0] space_energy;
    logic [ENERGY_W-1:0] mark_energy;

    fsksd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push_valid    (push_valid),
        .push_item     (push_item)
    );

    fsksd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .pop_item   (pop_item)
    );

    fsksd_lane u_space_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .diff    (cur_item.diff),
        .phase   (cur_item.ph_space),
        .energy  (space_energy)
    );

    fsksd_lane u_mark_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .diff    (cur_item.diff),
        .phase   (cur_item.ph_mark),
        .energy  (mark_energy)
    );

    fsksd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .queue_empty   (queue_empty),
        .pop_item      (pop_item),
        .pop           (pop),
        .ctl           (ctl),
        .cur_item      (cur_item),
        .space_energy  (space_energy),
        .mark_energy   (mark_energy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: sv/fsksd_checker.sv
module fsksd_checker
    import fsksd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Without a word, the packed word field reads as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[WORD_W:1] == '0)
        else $error("packed word not zero without word flag");

    // The padding above the packed word is always zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:WORD_W+1] == '0)
        else $error("padding bits set");

    // No result is offered right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind fsk_sliding_dft_demodulator fsksd_checker u_checker (.*);
